// ===== src/assert_macros.svh =====
// Assertion macros shared by the replica target range mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define RTRM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RTRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rtrm_pkg.sv =====
// Types and constants shared by the replica target range mapper modules.
package rtrm_pkg;

    localparam int MAX_REPLICAS = 1024;
    localparam int CNT_W        = 11;
    localparam int IDX_W        = 10;
    localparam int RANK_W       = 16;
    localparam int N_W          = 28;
    localparam int QW           = 11;
    localparam int CFG_IDX_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GPN    = 3'd5;

    typedef enum logic [1:0] {
        KIND_BLOCK,
        KIND_SEND,
        KIND_NODE
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CNT_W-1:0]  limit;
        logic [N_W-1:0]    per;
        logic [CNT_W-1:0]  extra;
        logic [CNT_W-1:0]  thr;
        logic [CNT_W-1:0]  d;
        logic [RANK_W-1:0] g;
        logic [RANK_W-1:0] stride;
        logic [RANK_W-1:0] rem0;
        logic [N_W-1:0]    hi_lim;
        logic [N_W-1:0]    bias;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic             in_range;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] endv;
        logic [CNT_W-1:0] base;
        logic             za;
        logic             ca;
        logic             zb;
        logic             cb;
    } tag_t;

endpackage

// ===== src/rtrm_setup.sv =====
// Configuration registers and the sequencer that derives the balancing constants.
module rtrm_setup (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rtrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtrm_pkg::RANK_W-1:0]     cfg_data,
    output rtrm_pkg::cfg_t                  cfg_out,
    output logic                            cfg_ok
);

    typedef enum logic [3:0] {
        ST_CLAMP,
        ST_MUL,
        ST_N0,
        ST_NL,
        ST_BLK,
        ST_SEND,
        ST_THR,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    logic                           mode_reg;
    logic [rtrm_pkg::CNT_W-1:0]     src_cnt_reg;
    logic [rtrm_pkg::CNT_W-1:0]     dst_cnt_reg;
    logic [rtrm_pkg::RANK_W-1:0]    start_reg;
    logic [rtrm_pkg::RANK_W-1:0]    stride_reg;
    logic [rtrm_pkg::RANK_W-1:0]    gpn_reg;

    logic [rtrm_pkg::CNT_W-1:0]     s_reg;
    logic [rtrm_pkg::CNT_W-1:0]     d_reg;
    logic [rtrm_pkg::RANK_W-1:0]    g_reg;
    logic [rtrm_pkg::N_W-1:0]       last_reg;
    logic [rtrm_pkg::N_W-1:0]       dstride_reg;
    logic [rtrm_pkg::N_W-1:0]       n0_reg;
    logic [rtrm_pkg::RANK_W-1:0]    rem0_reg;
    logic [rtrm_pkg::N_W-1:0]       hi_lim_reg;
    logic [rtrm_pkg::N_W-1:0]       bias_reg;

    logic [rtrm_pkg::N_W-1:0]       quo_reg;
    logic [rtrm_pkg::RANK_W:0]      rem_reg;
    logic [rtrm_pkg::RANK_W-1:0]    dvs_reg;
    logic [4:0]                     cnt_reg;

    rtrm_pkg::kind_t                kind_reg;
    logic [rtrm_pkg::CNT_W-1:0]     limit_reg;
    logic [rtrm_pkg::N_W-1:0]       per_reg;
    logic [rtrm_pkg::CNT_W-1:0]     extra_reg;
    logic [rtrm_pkg::CNT_W-1:0]     thr_reg;

    logic [rtrm_pkg::RANK_W:0]      trial;
    logic [rtrm_pkg::N_W-1:0]       nodes;
    logic [2*rtrm_pkg::CNT_W-1:0]   thr_full;

    function automatic logic [rtrm_pkg::CNT_W-1:0] clamp_cnt(logic [rtrm_pkg::CNT_W-1:0] c);
        logic [rtrm_pkg::CNT_W-1:0] r;
        r = c;
        if (c == '0) begin
            r = rtrm_pkg::CNT_W'(1);
        end else if (c > rtrm_pkg::CNT_W'(rtrm_pkg::MAX_REPLICAS)) begin
            r = rtrm_pkg::CNT_W'(rtrm_pkg::MAX_REPLICAS);
        end
        return r;
    endfunction

    assign trial    = {rem_reg[rtrm_pkg::RANK_W-1:0], quo_reg[rtrm_pkg::N_W-1]};
    assign nodes    = quo_reg - n0_reg + rtrm_pkg::N_W'(1);
    assign thr_full = extra_reg * (per_reg[rtrm_pkg::CNT_W-1:0] + rtrm_pkg::CNT_W'(1));

    assign cfg_ready = 1'b1;
    assign cfg_ok    = (state_reg == ST_DONE);

    assign cfg_out.kind   = kind_reg;
    assign cfg_out.limit  = limit_reg;
    assign cfg_out.per    = per_reg;
    assign cfg_out.extra  = extra_reg;
    assign cfg_out.thr    = thr_reg;
    assign cfg_out.d      = d_reg;
    assign cfg_out.g      = g_reg;
    assign cfg_out.stride = stride_reg;
    assign cfg_out.rem0   = rem0_reg;
    assign cfg_out.hi_lim = hi_lim_reg;
    assign cfg_out.bias   = bias_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLAMP;
            mode_reg    <= 1'b0;
            src_cnt_reg <= rtrm_pkg::CNT_W'(1);
            dst_cnt_reg <= rtrm_pkg::CNT_W'(1);
            start_reg   <= '0;
            stride_reg  <= rtrm_pkg::RANK_W'(1);
            gpn_reg     <= rtrm_pkg::RANK_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                rtrm_pkg::REG_MODE:   mode_reg    <= cfg_data[0];
                rtrm_pkg::REG_SRC:    src_cnt_reg <= cfg_data[rtrm_pkg::CNT_W-1:0];
                rtrm_pkg::REG_DST:    dst_cnt_reg <= cfg_data[rtrm_pkg::CNT_W-1:0];
                rtrm_pkg::REG_START:  start_reg   <= cfg_data;
                rtrm_pkg::REG_STRIDE: stride_reg  <= cfg_data;
                rtrm_pkg::REG_GPN:    gpn_reg     <= cfg_data;
                default: ;
            endcase
            state_reg <= ST_CLAMP;
        end else begin
            case (state_reg)
                ST_CLAMP: begin
                    s_reg     <= clamp_cnt(src_cnt_reg);
                    d_reg     <= clamp_cnt(dst_cnt_reg);
                    g_reg     <= (gpn_reg == '0) ? rtrm_pkg::RANK_W'(1) : gpn_reg;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    last_reg    <= rtrm_pkg::N_W'(start_reg)
                                 + rtrm_pkg::N_W'((d_reg - rtrm_pkg::CNT_W'(1)) * stride_reg);
                    dstride_reg <= rtrm_pkg::N_W'(d_reg * stride_reg);
                    quo_reg     <= rtrm_pkg::N_W'(start_reg);
                    rem_reg     <= '0;
                    dvs_reg     <= g_reg;
                    cnt_reg     <= '0;
                    ret_reg     <= ST_N0;
                    state_reg   <= ST_DIV;
                end
                ST_N0: begin
                    n0_reg     <= quo_reg;
                    rem0_reg   <= rem_reg[rtrm_pkg::RANK_W-1:0];
                    hi_lim_reg <= dstride_reg + rtrm_pkg::N_W'(rem_reg[rtrm_pkg::RANK_W-1:0]);
                    bias_reg   <= rtrm_pkg::N_W'(stride_reg)
                                - rtrm_pkg::N_W'(rem_reg[rtrm_pkg::RANK_W-1:0])
                                - rtrm_pkg::N_W'(1);
                    quo_reg    <= last_reg;
                    rem_reg    <= '0;
                    dvs_reg    <= g_reg;
                    cnt_reg    <= '0;
                    ret_reg    <= ST_NL;
                    state_reg  <= ST_DIV;
                end
                ST_NL: begin
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    if (mode_reg) begin
                        kind_reg <= rtrm_pkg::KIND_NODE;
                        if (rtrm_pkg::N_W'(s_reg) >= nodes) begin
                            per_reg   <= rtrm_pkg::N_W'(1);
                            extra_reg <= '0;
                            limit_reg <= nodes[rtrm_pkg::CNT_W-1:0];
                            state_reg <= ST_DONE;
                        end else begin
                            limit_reg <= s_reg;
                            quo_reg   <= nodes;
                            dvs_reg   <= rtrm_pkg::RANK_W'(s_reg);
                            ret_reg   <= ST_BLK;
                            state_reg <= ST_DIV;
                        end
                    end else if (s_reg > d_reg) begin
                        kind_reg  <= rtrm_pkg::KIND_SEND;
                        limit_reg <= s_reg;
                        quo_reg   <= rtrm_pkg::N_W'(s_reg);
                        dvs_reg   <= rtrm_pkg::RANK_W'(d_reg);
                        ret_reg   <= ST_SEND;
                        state_reg <= ST_DIV;
                    end else if (s_reg == d_reg) begin
                        kind_reg  <= rtrm_pkg::KIND_BLOCK;
                        limit_reg <= s_reg;
                        per_reg   <= rtrm_pkg::N_W'(1);
                        extra_reg <= '0;
                        state_reg <= ST_DONE;
                    end else begin
                        kind_reg  <= rtrm_pkg::KIND_BLOCK;
                        limit_reg <= s_reg;
                        quo_reg   <= rtrm_pkg::N_W'(d_reg);
                        dvs_reg   <= rtrm_pkg::RANK_W'(s_reg);
                        ret_reg   <= ST_BLK;
                        state_reg <= ST_DIV;
                    end
                end
                ST_BLK: begin
                    per_reg   <= quo_reg;
                    extra_reg <= rem_reg[rtrm_pkg::CNT_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_SEND: begin
                    per_reg   <= quo_reg;
                    extra_reg <= rem_reg[rtrm_pkg::CNT_W-1:0];
                    state_reg <= ST_THR;
                end
                ST_THR: begin
                    thr_reg   <= thr_full[rtrm_pkg::CNT_W-1:0];
                    state_reg <= ST_DONE;
                end
                ST_DIV: begin
                    if (trial >= {1'b0, dvs_reg}) begin
                        rem_reg <= trial - {1'b0, dvs_reg};
                        quo_reg <= {quo_reg[rtrm_pkg::N_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[rtrm_pkg::N_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(rtrm_pkg::N_W - 1)) begin
                        state_reg <= ret_reg;
                    end
                end
                ST_DONE: ;
                default: state_reg <= ST_CLAMP;
            endcase
        end
    end

endmodule

// ===== src/rtrm_divpipe.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
module rtrm_divpipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [rtrm_pkg::N_W-1:0]       in_dvd_a,
    input  logic [rtrm_pkg::RANK_W-1:0]    in_dvs_a,
    input  logic [rtrm_pkg::N_W-1:0]       in_dvd_b,
    input  logic [rtrm_pkg::RANK_W-1:0]    in_dvs_b,
    input  rtrm_pkg::tag_t                 in_tag,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rtrm_pkg::QW-1:0]        out_q_a,
    output logic [rtrm_pkg::N_W-1:0]       out_r_a,
    output logic [rtrm_pkg::QW-1:0]        out_q_b,
    output rtrm_pkg::tag_t                 out_tag
);

    typedef struct packed {
        logic [rtrm_pkg::N_W-1:0]    rem;
        logic [rtrm_pkg::RANK_W-1:0] dvs;
        logic [rtrm_pkg::QW-1:0]     q;
    } lane_t;

    typedef struct packed {
        lane_t          a;
        lane_t          b;
        rtrm_pkg::tag_t tag;
    } stage_t;

    function automatic lane_t div_step(lane_t l, int unsigned sh);
        lane_t                    r;
        logic [rtrm_pkg::N_W-1:0] ds;
        r  = l;
        ds = rtrm_pkg::N_W'(l.dvs) << sh;
        if (l.rem >= ds) begin
            r.rem = l.rem - ds;
            r.q   = {l.q[rtrm_pkg::QW-2:0], 1'b1};
        end else begin
            r.q   = {l.q[rtrm_pkg::QW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic stage_t stage_step(stage_t s, int unsigned sh);
        stage_t r;
        r   = s;
        r.a = div_step(s.a, sh);
        r.b = div_step(s.b, sh);
        return r;
    endfunction

    stage_t st_reg [rtrm_pkg::QW];
    stage_t src    [rtrm_pkg::QW];
    logic   v_reg  [rtrm_pkg::QW];
    logic   v_src  [rtrm_pkg::QW];
    logic   rdy    [rtrm_pkg::QW+1];

    assign src[0].a.rem = in_dvd_a;
    assign src[0].a.dvs = in_dvs_a;
    assign src[0].a.q   = '0;
    assign src[0].b.rem = in_dvd_b;
    assign src[0].b.dvs = in_dvs_b;
    assign src[0].b.q   = '0;
    assign src[0].tag   = in_tag;
    assign v_src[0]     = in_valid;
    assign rdy[rtrm_pkg::QW] = out_ready;

    for (genvar k = 0; k < rtrm_pkg::QW; k++) begin : g_stage
        if (k > 0) begin : g_link
            assign src[k]   = st_reg[k-1];
            assign v_src[k] = v_reg[k-1];
        end
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                st_reg[k] <= stage_step(src[k], rtrm_pkg::QW - 1 - k);
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[rtrm_pkg::QW-1];
    assign out_q_a   = st_reg[rtrm_pkg::QW-1].a.q;
    assign out_r_a   = st_reg[rtrm_pkg::QW-1].a.rem;
    assign out_q_b   = st_reg[rtrm_pkg::QW-1].b.q;
    assign out_tag   = st_reg[rtrm_pkg::QW-1].tag;

endmodule

// ===== src/replica_target_range_mapper_core.sv =====
// Pipeline: 4 front stages, 11 divider stages and 1 output register lie between
// an accepted request and its result; one request per cycle is sustained while
// m_ready stays high and no derivation pass runs. The 11-stage divider pipeline
// yields one quotient bit per stage. Reset and every configuration write start a
// derivation pass of up to three serial divisions while s_ready stays low.
// Reset is synchronous, active low; it clears valid bits and config registers.
`include "assert_macros.svh"

module replica_target_range_mapper_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtrm_pkg::RANK_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rtrm_pkg::IDX_W-1:0]     s_source_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rtrm_pkg::CNT_W-1:0]     m_range_first,
    output logic [rtrm_pkg::CNT_W-1:0]     m_range_end
);

    typedef struct packed {
        rtrm_pkg::kind_t              kind;
        logic                         in_range;
        logic                         lt_extra;
        logic [rtrm_pkg::IDX_W-1:0]   mn;
        logic [rtrm_pkg::N_W-1:0]     prod;
        logic [rtrm_pkg::IDX_W-1:0]   dvd_u;
        logic [rtrm_pkg::CNT_W-1:0]   dvs_u;
        logic [rtrm_pkg::CNT_W-1:0]   base;
    } s1_t;

    typedef struct packed {
        rtrm_pkg::kind_t              kind;
        logic                         in_range;
        logic [rtrm_pkg::N_W-1:0]     first;
        logic [rtrm_pkg::N_W-1:0]     endv;
        logic [rtrm_pkg::IDX_W-1:0]   dvd_u;
        logic [rtrm_pkg::CNT_W-1:0]   dvs_u;
        logic [rtrm_pkg::CNT_W-1:0]   base;
    } s2_t;

    typedef struct packed {
        rtrm_pkg::kind_t              kind;
        logic                         in_range;
        logic [rtrm_pkg::N_W-1:0]     ka;
        logic [rtrm_pkg::N_W-1:0]     kb;
        logic [rtrm_pkg::CNT_W-1:0]   first;
        logic [rtrm_pkg::CNT_W-1:0]   endv;
        logic [rtrm_pkg::IDX_W-1:0]   dvd_u;
        logic [rtrm_pkg::CNT_W-1:0]   dvs_u;
        logic [rtrm_pkg::CNT_W-1:0]   base;
    } s3_t;

    typedef struct packed {
        logic [rtrm_pkg::N_W-1:0]     dvd_a;
        logic [rtrm_pkg::RANK_W-1:0]  dvs_a;
        logic [rtrm_pkg::N_W-1:0]     dvd_b;
        logic [rtrm_pkg::RANK_W-1:0]  dvs_b;
        rtrm_pkg::tag_t               tag;
    } s4_t;

    rtrm_pkg::cfg_t cfg;
    logic           cfg_ok;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;

    logic                          div_in_ready;
    logic                          div_out_valid;
    logic [rtrm_pkg::QW-1:0]       div_q_a;
    logic [rtrm_pkg::N_W-1:0]      div_r_a;
    logic [rtrm_pkg::QW-1:0]       div_q_b;
    rtrm_pkg::tag_t                div_tag;

    logic [rtrm_pkg::CNT_W-1:0]    first_reg, first_next;
    logic [rtrm_pkg::CNT_W-1:0]    end_reg, end_next;

    logic [rtrm_pkg::N_W+rtrm_pkg::IDX_W-1:0]    prod_full;
    logic [rtrm_pkg::N_W+rtrm_pkg::RANK_W-1:0]   ka_full;
    logic [rtrm_pkg::N_W+rtrm_pkg::RANK_W-1:0]   kb_full;
    logic                          ge_thr;
    logic [rtrm_pkg::CNT_W-1:0]    a_val, b_val, dst;

    rtrm_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg),
        .cfg_ok    (cfg_ok)
    );

    assign rdy_o   = !vo_reg || m_ready;
    assign rdy4    = !v4_reg || div_in_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1 && cfg_ok;

    assign prod_full = s_source_index * cfg.per;
    assign ge_thr    = {1'b0, s_source_index} >= cfg.thr;

    always_comb begin
        s1_next.kind     = cfg.kind;
        s1_next.in_range = {1'b0, s_source_index} < cfg.limit;
        s1_next.lt_extra = {1'b0, s_source_index} < cfg.extra;
        s1_next.mn       = s1_next.lt_extra ? s_source_index : cfg.extra[rtrm_pkg::IDX_W-1:0];
        s1_next.prod     = prod_full[rtrm_pkg::N_W-1:0];
        if (ge_thr) begin
            s1_next.dvd_u = s_source_index - cfg.thr[rtrm_pkg::IDX_W-1:0];
            s1_next.dvs_u = cfg.per[rtrm_pkg::CNT_W-1:0];
            s1_next.base  = cfg.extra;
        end else begin
            s1_next.dvd_u = s_source_index;
            s1_next.dvs_u = cfg.per[rtrm_pkg::CNT_W-1:0] + rtrm_pkg::CNT_W'(1);
            s1_next.base  = '0;
        end
    end

    always_comb begin
        s2_next.kind     = s1_reg.kind;
        s2_next.in_range = s1_reg.in_range;
        s2_next.first    = s1_reg.prod + rtrm_pkg::N_W'(s1_reg.mn);
        s2_next.endv     = s2_next.first + cfg.per + rtrm_pkg::N_W'(s1_reg.lt_extra);
        s2_next.dvd_u    = s1_reg.dvd_u;
        s2_next.dvs_u    = s1_reg.dvs_u;
        s2_next.base     = s1_reg.base;
    end

    assign ka_full = s2_reg.first * cfg.g;
    assign kb_full = s2_reg.endv * cfg.g;

    always_comb begin
        s3_next.kind     = s2_reg.kind;
        s3_next.in_range = s2_reg.in_range;
        s3_next.ka       = ka_full[rtrm_pkg::N_W-1:0];
        s3_next.kb       = kb_full[rtrm_pkg::N_W-1:0];
        s3_next.first    = s2_reg.first[rtrm_pkg::CNT_W-1:0];
        s3_next.endv     = s2_reg.endv[rtrm_pkg::CNT_W-1:0];
        s3_next.dvd_u    = s2_reg.dvd_u;
        s3_next.dvs_u    = s2_reg.dvs_u;
        s3_next.base     = s2_reg.base;
    end

    // A bound at or below the start rank maps to replica zero; one past the
    // last replica's rank caps at the destination count.
    always_comb begin
        s4_next.tag.kind     = s3_reg.kind;
        s4_next.tag.in_range = s3_reg.in_range;
        s4_next.tag.first    = s3_reg.first;
        s4_next.tag.endv     = s3_reg.endv;
        s4_next.tag.base     = s3_reg.base;
        s4_next.tag.za       = s3_reg.ka <= rtrm_pkg::N_W'(cfg.rem0);
        s4_next.tag.ca       = s3_reg.ka > cfg.hi_lim;
        s4_next.tag.zb       = s3_reg.kb <= rtrm_pkg::N_W'(cfg.rem0);
        s4_next.tag.cb       = s3_reg.kb > cfg.hi_lim;
        s4_next.dvd_b        = s3_reg.kb + cfg.bias;
        s4_next.dvs_b        = cfg.stride;
        if (s3_reg.kind == rtrm_pkg::KIND_SEND) begin
            s4_next.dvd_a = rtrm_pkg::N_W'(s3_reg.dvd_u);
            s4_next.dvs_a = rtrm_pkg::RANK_W'(s3_reg.dvs_u);
        end else begin
            s4_next.dvd_a = s3_reg.ka + cfg.bias;
            s4_next.dvs_a = cfg.stride;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid && cfg_ok;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
            if (rdy_o) begin
                vo_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg <= s1_next;
        end
        if (rdy2) begin
            s2_reg <= s2_next;
        end
        if (rdy3) begin
            s3_reg <= s3_next;
        end
        if (rdy4) begin
            s4_reg <= s4_next;
        end
        if (rdy_o) begin
            first_reg <= first_next;
            end_reg   <= end_next;
        end
    end

    rtrm_divpipe u_divpipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .in_dvd_a  (s4_reg.dvd_a),
        .in_dvs_a  (s4_reg.dvs_a),
        .in_dvd_b  (s4_reg.dvd_b),
        .in_dvs_b  (s4_reg.dvs_b),
        .in_tag    (s4_reg.tag),
        .out_valid (div_out_valid),
        .out_ready (rdy_o),
        .out_q_a   (div_q_a),
        .out_r_a   (div_r_a),
        .out_q_b   (div_q_b),
        .out_tag   (div_tag)
    );

    assign a_val = div_tag.za ? '0 : (div_tag.ca ? cfg.d : div_q_a);
    assign b_val = div_tag.zb ? '0 : (div_tag.cb ? cfg.d : div_q_b);
    assign dst   = div_q_a + div_tag.base;

    always_comb begin
        first_next = '0;
        end_next   = '0;
        if (div_tag.in_range) begin
            case (div_tag.kind)
                rtrm_pkg::KIND_BLOCK: begin
                    first_next = div_tag.first;
                    end_next   = div_tag.endv;
                end
                rtrm_pkg::KIND_SEND: begin
                    if ((div_r_a == '0) && (dst < cfg.d)) begin
                        first_next = dst;
                        end_next   = dst + rtrm_pkg::CNT_W'(1);
                    end
                end
                rtrm_pkg::KIND_NODE: begin
                    if (a_val < b_val) begin
                        first_next = a_val;
                        end_next   = b_val;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = vo_reg;
    assign m_range_first = first_reg;
    assign m_range_end   = end_reg;

    `RTRM_ASSERT_RST(a_range_order, aclk, aresetn, m_valid |-> (m_range_first <= m_range_end), "range first above range end")
    `RTRM_ASSERT_RST(a_range_cap, aclk, aresetn, m_valid |-> (m_range_end <= cfg.d), "range end beyond destination count")
    `RTRM_ASSERT_RST(a_cfg_blocks_input, aclk, aresetn, (cfg_valid && cfg_ready) |=> !s_ready, "request accepted during constant derivation")
    `RTRM_ASSERT_ALWAYS(a_no_accept_busy, aclk, !cfg_ok |-> !s_ready, "ready raised before constants are derived")

endmodule
